// File: rtl/core/sha512_pkg.sv
package sha512_pkg;

  typedef logic [63:0] word_t;

  localparam int unsigned NumRounds = 80;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenOffset = 7'd112;

  localparam word_t InitH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       load;   // copy hash words into working variables
    logic       round;  // perform one round
    logic [6:0] rnd;    // round number
  } rnd_ctrl_t;

  function automatic word_t ror64(word_t x, int unsigned n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: rtl/core/sha512_hash_engine_core.sv
// A non-last word keeps busy high while its valid bytes are written into the
// block; no new word is accepted until busy falls.
// A word that fills the block adds a compression (load, 80 rounds, add).
// Last word: its bytes, padding one byte per cycle up to byte 112 (paused while
// a full block is compressed), the length, one or two compressions, then 8 digest words.
// Reset clears hash state to the initial values; digest strobes cannot stall.
module sha512_hash_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        digest_valid_o,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        final_word_o
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StBytes, StLoad, StRound, StAdd, StOut
  } state_e;

  state_e      state_q;
  word_t       h_q [8];
  word_t       w_q [16];
  logic [6:0]  nbytes_q;
  logic [127:0] len_q;
  logic [63:0] word_q;
  logic [3:0]  cnt_q;
  logic        last_q;
  logic        padded_q;   // 0x80 already written
  logic        lendone_q;  // length written into current block
  logic [6:0]  rnd_q;
  logic [2:0]  oidx_q;
  word_t       v [8];
  word_t       wnew, wcur;
  rnd_ctrl_t   ctrl;
  logic [127:0] bitlen;
  logic [7:0]  byte_in;
  logic        dv_q;

  // message schedule: sliding window of 16 words
  always_comb begin
    wnew = w_q[0] + (ror64(w_q[1], 1) ^ ror64(w_q[1], 8) ^ (w_q[1] >> 7))
         + w_q[9] + (ror64(w_q[14], 19) ^ ror64(w_q[14], 61) ^ (w_q[14] >> 6));
    wcur = w_q[0];
    bitlen = len_q << 3;
    byte_in = padded_q ? 8'h00 : (cnt_q != 4'd0 ? word_q[63:56] : PadByte);
    ctrl.load  = (state_q == StLoad);
    ctrl.round = (state_q == StRound);
    ctrl.rnd   = rnd_q;
  end

  sha512_round u_round (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .h_i   (h_q),
    .w_i   (wcur),
    .v_o   (v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      h_q       <= InitH;
      nbytes_q  <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      padded_q  <= 1'b0;
      lendone_q <= 1'b0;
      rnd_q     <= '0;
      oidx_q    <= '0;
      dv_q      <= 1'b0;
    end else begin
      dv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            word_q <= message_word_i;
            cnt_q  <= (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
            last_q <= last_word_i;
            len_q  <= len_q + {124'd0, (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i};
            state_q <= StBytes;
          end
        end
        StBytes: begin
          // take one byte per cycle; padding follows on the last word
          if (cnt_q == 4'd0 && !last_q) begin
            state_q <= StIdle;
          end else if (cnt_q == 4'd0 && padded_q && nbytes_q == LenOffset) begin
            w_q[14] <= bitlen[127:64];
            w_q[15] <= bitlen[63:0];
            lendone_q <= 1'b1;
            nbytes_q <= '0;
            state_q <= StLoad;
          end else begin
            w_q[nbytes_q[6:3]][(7 - nbytes_q[2:0]) * 8 +: 8] <= byte_in;
            if (cnt_q != 4'd0) begin
              cnt_q  <= cnt_q - 4'd1;
              word_q <= {word_q[55:0], 8'h00};
            end else begin
              padded_q <= 1'b1;
            end
            nbytes_q <= nbytes_q + 7'd1;
            if (nbytes_q == 7'd127) state_q <= StLoad;
          end
        end
        StLoad: begin
          rnd_q   <= '0;
          state_q <= StRound;
        end
        StRound: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnew;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'(NumRounds - 1)) state_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[i];
          nbytes_q <= '0;
          if (lendone_q) begin
            oidx_q  <= '0;
            state_q <= StOut;
          end else begin
            state_q <= StBytes;
          end
        end
        StOut: begin
          // one digest word per cycle, then reinitialize
          dv_q   <= 1'b1;
          digest_word_o <= h_q[oidx_q];
          word_index_o  <= oidx_q;
          final_word_o  <= (oidx_q == 3'd7);
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            h_q       <= InitH;
            len_q     <= '0;
            padded_q  <= 1'b0;
            lendone_q <= 1'b0;
            last_q    <= 1'b0;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign digest_valid_o = dv_q;
endmodule

// File: rtl/core/sha512_round.sv
module sha512_round (
  input  logic                 clk_i,
  input  sha512_pkg::rnd_ctrl_t ctrl_i,
  input  sha512_pkg::word_t    h_i [8],
  input  sha512_pkg::word_t    w_i,
  output sha512_pkg::word_t    v_o [8]
);
  import sha512_pkg::*;

  word_t v_q [8];
  word_t t1, t2;

  // one compression round
  always_comb begin
    t1 = v_q[7] + (ror64(v_q[4], 14) ^ ror64(v_q[4], 18) ^ ror64(v_q[4], 41))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[ctrl_i.rnd] + w_i;
    t2 = (ror64(v_q[0], 28) ^ ror64(v_q[0], 34) ^ ror64(v_q[0], 39))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= h_i;
    end else if (ctrl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign v_o = v_q;
endmodule

// File: rtl/core/sha512_checker.sv
module sha512_core_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       digest_valid_o,
  input logic [2:0] word_index_o,
  input logic       final_word_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  a_final_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o |-> (final_word_o == (word_index_o == 3'd7)))
    else $error("final flag mismatch");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && !final_word_o |=> digest_valid_o &&
      word_index_o == $past(word_index_o) + 3'd1) else $error("digest gap");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && !final_word_o |-> busy_o) else $error("idle mid digest");
endmodule

bind sha512_hash_engine_core sha512_core_sva u_chk (.*);

// File: tb/sha512_checker.sv
module sha512_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic        digest_valid_i,
  input  logic [63:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        final_word_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha512_pkg::*;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  word_t       hash_q [8];
  word_t       block_q [16];
  logic [6:0]  fill_q;
  logic [127:0] byte_count_q;
  digest_t     digest_queue [$];

  // run one 80-round compression over the block buffer
  function automatic void compress_block();
    word_t w [80];
    word_t v [8];
    word_t s0, s1, t1, t2, e, a;
    for (int t = 0; t < 16; t++) w[t] = block_q[t];
    for (int t = 16; t < 80; t++) begin
      s0 = {w[t-15][0], w[t-15][63:1]} ^ {w[t-15][7:0], w[t-15][63:8]} ^ (w[t-15] >> 7);
      s1 = {w[t-2][18:0], w[t-2][63:19]} ^ {w[t-2][60:0], w[t-2][63:61]} ^ (w[t-2] >> 6);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 80; t++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
         + ((e & v[5]) ^ (~e & v[6])) + RoundK[t] + w[t];
      t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] = hash_q[i] + v[i];
  endfunction

  // pack one byte, compress on a full block
  function automatic void push_byte(logic [7:0] b);
    block_q[fill_q[6:3]][8 * (7 - fill_q[2:0]) +: 8] = b;
    fill_q++;
    if (fill_q == 7'd0) compress_block();
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_q[i] = InitH[i];
    fill_q = '0;
    byte_count_q = '0;
  endfunction

  // absorb one accepted word and queue the digest when it ends the message
  function automatic void absorb_word(logic [63:0] data, logic [3:0] cnt, logic last);
    logic [127:0] bit_len;
    int n;
    n = (cnt > 8) ? 8 : cnt;
    for (int i = 0; i < n; i++) push_byte(data[56 - 8 * i +: 8]);
    byte_count_q = byte_count_q + 128'(n);
    if (!last) return;
    bit_len = byte_count_q << 3;
    push_byte(PadByte);
    while (fill_q != LenOffset) push_byte(8'h00);
    for (int i = 0; i < 16; i++) push_byte(bit_len[120 - 8 * i +: 8]);
    for (int i = 0; i < 8; i++)
      digest_queue.push_back('{hash_q[i], 3'(i), i == 7});
    restart_hash();
  endfunction

  always @(posedge clk_i) begin
    digest_t want;
    if (!rst_ni) begin
      // hold the model in its reset state
      restart_hash();
      digest_queue.delete();
    end else begin
      if (start_i && !busy_i)
        absorb_word(message_word_i, valid_bytes_i, last_word_i);
      // compare each strobed word with the oldest expectation
      if (digest_valid_i) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %h", digest_word_i);
          fail_count_o++;
        end else begin
          want = digest_queue.pop_front();
          if (want.digest_word !== digest_word_i) begin
            $error("digest_word expected %h actual %h", want.digest_word, digest_word_i);
            fail_count_o++;
          end
          if (want.word_index !== word_index_i) begin
            $error("word_index expected %0d actual %0d", want.word_index, word_index_i);
            fail_count_o++;
          end
          if (want.final_word !== final_word_i) begin
            $error("final_word expected %0d actual %0d", want.final_word, final_word_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o <= digest_queue.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] message_word_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        last_word_i = 1'b0;
  logic        digest_valid_o;
  logic [63:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        final_word_o;
  int          fail_count;
  int          pending;
  int          gap_pct;
  longint      cycle_count = 0;

  localparam longint CycleLimit = 400000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sha512_hash_engine_core uut (.*);

  sha512_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .message_word_i, .valid_bytes_i,
    .last_word_i, .digest_valid_i(digest_valid_o), .digest_word_i(digest_word_o),
    .word_index_i(word_index_o), .final_word_i(final_word_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one word, holding start until it is accepted
  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    message_word_i <= data;
    valid_bytes_i <= cnt;
    last_word_i <= last;
    do @(posedge clk_i); while (busy_o);
  endtask

  // send a message of full_words words, ending with a last word of random byte count
  task automatic send_message(int full_words);
    logic [63:0] rnd;
    for (int i = 0; i < full_words; i++) begin
      rnd = {$urandom, $urandom};
      send_word(rnd, ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'd8, 1'b0);
    end
    rnd = {$urandom, $urandom};
    send_word(rnd, 4'($urandom_range(15)), 1'b1);
  endtask

  initial begin
    gap_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, extremes, over-count, boundary lengths
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word(64'h6162638000000000, 4'd3, 1'b1);
    send_word('0, 4'd9, 1'b0);
    send_word(64'h0123456789abcdef, 4'd5, 1'b0);
    send_word('1, 4'd0, 1'b1);
    for (int i = 0; i < 13; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word('1, 4'd7, 1'b1);
    send_word('1, 4'd1, 1'b0);
    send_word('0, 4'd8, 1'b1);

    // random messages over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 8 : (phase == 1) ? 77 : 0;
      for (int m = 0; m < 18; m++)
        send_message(($urandom_range(9) == 0) ? $urandom_range(20, 34)
                                              : $urandom_range(0, 10));
    end
    start_i <= 1'b0;

    // drain the digest queue, then allow for a tail
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
